// ===== src/skf_pkg.sv =====
// Shared types and constants of the scalar Kalman filter block.
// Used by every module under src; no dependencies of its own.
package skf_pkg;

   // Word formats: estimate and measurement are signed Q16.16, covariance unsigned
   localparam int DATA_WIDTH = 32;
   localparam int COV_WIDTH  = DATA_WIDTH - 1;
   localparam int GAIN_BITS  = 16;

   // Shared multiplier: residual magnitude (or covariance) times gain (or 1 - gain)
   localparam int MAG_WIDTH  = DATA_WIDTH + 1;
   localparam int FACT_WIDTH = GAIN_BITS + 1;
   localparam int PROD_WIDTH = MAG_WIDTH + FACT_WIDTH;

   // Stream payload widths, rounded up to whole bytes
   localparam int REQ_TDATA_WIDTH = ((3 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS_WIDTH = DATA_WIDTH + GAIN_BITS + COV_WIDTH;
   localparam int RSP_TDATA_WIDTH = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   // Register port
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_INDEX_WIDTH = 2;

   localparam logic [REG_INDEX_WIDTH-1:0] REG_Q_VARIANCE        = 2'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_R_VARIANCE        = 2'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_START_COVARIANCE  = 2'd2;

   localparam logic [COV_WIDTH-1:0] Q_VARIANCE_RESET        = COV_WIDTH'(1311);
   localparam logic [COV_WIDTH-1:0] R_VARIANCE_RESET        = COV_WIDTH'(6554);
   localparam logic [COV_WIDTH-1:0] START_COVARIANCE_RESET  = COV_WIDTH'(65536);

   // Request kinds carried on tuser
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_RESET  = 1'b1;

   typedef struct packed {
      logic [COV_WIDTH-1:0] q_variance;
      logic [COV_WIDTH-1:0] r_variance;
      logic [COV_WIDTH-1:0] start_covariance;
   } csr_regs_type;

   // Start of a gain division: dividend * 2^GAIN_BITS / divisor
   typedef struct packed {
      logic                  start;
      logic [COV_WIDTH-1:0]  dividend;
      logic [DATA_WIDTH-1:0] divisor;
   } div_req_type;

endpackage

// ===== src/skf_csr.sv =====
// Configuration registers of the scalar Kalman filter behind an APB-style port.
// Depends on skf_pkg.
module skf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [skf_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [skf_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [skf_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready,
   output skf_pkg::csr_regs_type              regs
);

   skf_pkg::csr_regs_type regs_ff, regs_in;
   logic [skf_pkg::REG_INDEX_WIDTH-1:0] index;
   logic [skf_pkg::COV_WIDTH-1:0]       wdata;
   logic                                write_en;

   assign index    = csr_paddr[skf_pkg::REG_INDEX_WIDTH+1:2];
   assign wdata    = csr_pwdata[skf_pkg::COV_WIDTH-1:0];
   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign regs = regs_ff;

   // Register write decode
   always_comb begin
      regs_in = regs_ff;
      if (write_en) begin
         unique case (index)
            skf_pkg::REG_Q_VARIANCE:        regs_in.q_variance        = wdata;
            skf_pkg::REG_R_VARIANCE:        regs_in.r_variance        = wdata;
            skf_pkg::REG_START_COVARIANCE:  regs_in.start_covariance  = wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.q_variance        <= skf_pkg::Q_VARIANCE_RESET;
         regs_ff.r_variance        <= skf_pkg::R_VARIANCE_RESET;
         regs_ff.start_covariance  <= skf_pkg::START_COVARIANCE_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   // Readback; unused addresses read zero
   always_comb begin
      unique case (index)
         skf_pkg::REG_Q_VARIANCE:
            csr_prdata = skf_pkg::CSR_DATA_WIDTH'(regs_ff.q_variance);
         skf_pkg::REG_R_VARIANCE:
            csr_prdata = skf_pkg::CSR_DATA_WIDTH'(regs_ff.r_variance);
         skf_pkg::REG_START_COVARIANCE:
            csr_prdata = skf_pkg::CSR_DATA_WIDTH'(regs_ff.start_covariance);
         default:
            csr_prdata = '0;
      endcase
   end

endmodule

// ===== src/skf_div.sv =====
// Radix-2 restoring divider for the filter gain, one quotient bit per cycle.
// Depends on skf_pkg.
module skf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  skf_pkg::div_req_type          req,
   output logic [skf_pkg::GAIN_BITS-1:0] quotient,
   output logic                          done
);

   localparam int CountWidth = $clog2(skf_pkg::GAIN_BITS + 1);

   logic [skf_pkg::DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [skf_pkg::DATA_WIDTH-1:0] divisor_ff, divisor_in;
   logic [skf_pkg::GAIN_BITS-1:0]  quot_ff, quot_in;
   logic [CountWidth-1:0]          count_ff, count_in;
   logic                           done_ff, done_in;
   logic [skf_pkg::DATA_WIDTH:0]   shifted;
   logic [skf_pkg::DATA_WIDTH:0]   divisor_ext;
   logic [skf_pkg::DATA_WIDTH:0]   diff;
   logic                           fits;

   // One shift-compare-subtract step; the remainder never exceeds the divisor
   assign shifted     = {rem_ff, 1'b0};
   assign divisor_ext = {1'b0, divisor_ff};
   assign diff        = shifted - divisor_ext;
   assign fits        = shifted >= divisor_ext;

   always_comb begin
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      count_in   = count_ff;
      done_in    = 1'b0;
      if (req.start) begin
         rem_in     = skf_pkg::DATA_WIDTH'(req.dividend);
         divisor_in = req.divisor;
         quot_in    = '0;
         count_in   = CountWidth'(skf_pkg::GAIN_BITS);
      end else if (count_ff != '0) begin
         rem_in   = fits ? diff[skf_pkg::DATA_WIDTH-1:0] : shifted[skf_pkg::DATA_WIDTH-1:0];
         quot_in  = {quot_ff[skf_pkg::GAIN_BITS-2:0], fits};
         count_in = count_ff - CountWidth'(1);
         done_in  = count_ff == CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

// ===== src/skf_mul.sv =====
// Shared registered multiplier: correction term and covariance scaling.
// Depends on skf_pkg.
module skf_mul (
   input  logic                           clock,
   input  logic [skf_pkg::MAG_WIDTH-1:0]  mul_a,
   input  logic [skf_pkg::FACT_WIDTH-1:0] mul_b,
   output logic [skf_pkg::PROD_WIDTH-1:0] product
);

   logic [skf_pkg::PROD_WIDTH-1:0] prod_ff, prod_in;

   assign prod_in = skf_pkg::PROD_WIDTH'(mul_a) * skf_pkg::PROD_WIDTH'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

// ===== src/skf_core.sv =====
// Sequencer and state of the scalar Kalman filter: predict, gain, correct.
// Depends on skf_pkg; drives skf_div and skf_mul.
module skf_core (
   input  logic                           clock,
   input  logic                           reset,
   input  skf_pkg::csr_regs_type          regs,
   // request word
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_kind,
   input  logic [skf_pkg::DATA_WIDTH-1:0] measurement,
   input  logic [skf_pkg::DATA_WIDTH-1:0] reset_estimate,
   input  logic [skf_pkg::DATA_WIDTH-1:0] reset_covariance,
   // result word
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [skf_pkg::DATA_WIDTH-1:0] estimate_out,
   output logic [skf_pkg::GAIN_BITS-1:0]  gain_out,
   output logic [skf_pkg::COV_WIDTH-1:0]  covariance_out,
   // divider
   output skf_pkg::div_req_type           div_req,
   input  logic [skf_pkg::GAIN_BITS-1:0]  div_quotient,
   input  logic                           div_done,
   // multiplier
   output logic [skf_pkg::MAG_WIDTH-1:0]  mul_a,
   output logic [skf_pkg::FACT_WIDTH-1:0] mul_b,
   input  logic [skf_pkg::PROD_WIDTH-1:0] product
);

   localparam int Dw      = skf_pkg::DATA_WIDTH;
   localparam int Cw      = skf_pkg::COV_WIDTH;
   localparam int Gb      = skf_pkg::GAIN_BITS;
   localparam int CorrW   = skf_pkg::PROD_WIDTH - Gb;
   localparam int UpdW    = Dw + 3;
   localparam logic [Cw-1:0] CovMax = '1;
   localparam logic [Dw-1:0] EstMax = {1'b0, {(Dw-1){1'b1}}};
   localparam logic [Dw-1:0] EstMin = {1'b1, {(Dw-1){1'b0}}};

   typedef enum logic [2:0] {
      IDLE, PRED, DEN, DIV, MUL1, CORR, COV, OUT
   } state_type;

   state_type        state_ff, state_in;
   logic             init_ff, init_in;
   logic [Dw-1:0]    est_ff, est_in;
   logic [Cw-1:0]    cov_ff, cov_in;
   logic [Gb-1:0]    gain_ff, gain_in;
   logic [Dw-1:0]    meas_ff, meas_in;
   logic [Dw:0]      mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [Dw-1:0]    out_est_ff, out_est_in;
   logic [Gb-1:0]    out_gain_ff, out_gain_in;
   logic [Cw-1:0]    out_cov_ff, out_cov_in;

   logic [Dw-1:0]    pred_sum;
   logic [Cw-1:0]    pred_cov;
   logic [Dw-1:0]    den;
   logic [Dw:0]      residual;
   logic [Dw:0]      residual_mag;
   logic [skf_pkg::PROD_WIDTH-1:0] corr_sum;
   logic [CorrW-1:0] corr;
   logic [UpdW-1:0]  est_ext;
   logic [UpdW-1:0]  corr_ext;
   logic [UpdW-1:0]  upd;
   logic             upd_fits;
   logic [Dw-1:0]    est_sat;
   logic [skf_pkg::FACT_WIDTH-1:0] one_minus_gain;

   // Predict: P + Q saturated to the covariance range
   assign pred_sum = {1'b0, cov_ff} + {1'b0, regs.q_variance};
   assign pred_cov = pred_sum[Dw-1] ? CovMax : pred_sum[Cw-1:0];

   // Gain denominator P + R
   assign den = {1'b0, cov_ff} + {1'b0, regs.r_variance};

   // Residual z - x as sign and magnitude
   assign residual     = {meas_ff[Dw-1], meas_ff} - {est_ff[Dw-1], est_ff};
   assign residual_mag = residual[Dw] ? (~residual + (Dw+1)'(1)) : residual;

   // Correction K * |z - x|, rounded half away from zero on the magnitude
   assign corr_sum = product + skf_pkg::PROD_WIDTH'(1 << (Gb - 1));
   assign corr     = corr_sum[skf_pkg::PROD_WIDTH-1:Gb];
   assign est_ext  = {{(UpdW-Dw){est_ff[Dw-1]}}, est_ff};
   assign corr_ext = UpdW'(corr);
   assign upd      = neg_ff ? (est_ext - corr_ext) : (est_ext + corr_ext);
   assign upd_fits = (&upd[UpdW-1:Dw-1]) || !(|upd[UpdW-1:Dw-1]);
   assign est_sat  = upd_fits ? upd[Dw-1:0] : (upd[UpdW-1] ? EstMin : EstMax);

   assign one_minus_gain = skf_pkg::FACT_WIDTH'(1 << Gb) - skf_pkg::FACT_WIDTH'(gain_ff);

   // Multiplier operands: residual times gain, then covariance times (1 - K)
   always_comb begin
      if (state_ff == MUL1) begin
         mul_a = mag_ff;
         mul_b = {1'b0, gain_ff};
      end else begin
         mul_a = skf_pkg::MAG_WIDTH'(cov_ff);
         mul_b = one_minus_gain;
      end
   end

   assign req_tready = state_ff == IDLE;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      est_in       = est_ff;
      cov_in       = cov_ff;
      gain_in      = gain_ff;
      meas_in      = meas_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_est_in   = out_est_ff;
      out_gain_in  = out_gain_ff;
      out_cov_in   = out_cov_ff;
      div_req.start    = 1'b0;
      div_req.dividend = cov_ff;
      div_req.divisor  = den;

      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               init_in = 1'b1;
               if (req_kind == skf_pkg::REQ_RESET) begin
                  est_in   = reset_estimate;
                  cov_in   = reset_covariance[Dw-1] ? '0 : reset_covariance[Cw-1:0];
                  gain_in  = '0;
                  state_in = OUT;
               end else begin
                  meas_in = measurement;
                  if (!init_ff) begin
                     est_in = measurement;
                     cov_in = regs.start_covariance;
                  end
                  state_in = PRED;
               end
            end
         end
         PRED: begin
            cov_in   = pred_cov;
            state_in = DEN;
         end
         DEN: begin
            if (den[Dw-1:1] == '0) begin
               gain_in  = '0;
               state_in = OUT;
            end else begin
               div_req.start = 1'b1;
               mag_in   = residual_mag;
               neg_in   = residual[Dw];
               state_in = DIV;
            end
         end
         DIV: begin
            if (div_done) begin
               gain_in  = div_quotient;
               state_in = MUL1;
            end
         end
         MUL1: begin
            state_in = CORR;
         end
         CORR: begin
            est_in   = est_sat;
            state_in = COV;
         end
         COV: begin
            cov_in   = product[Gb +: Cw];
            state_in = OUT;
         end
         OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_est_in   = est_ff;
               out_gain_in  = gain_ff;
               out_cov_in   = cov_ff;
               state_in     = IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         init_ff      <= 1'b0;
         est_ff       <= '0;
         cov_ff       <= '0;
         gain_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      meas_ff     <= meas_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      out_est_ff  <= out_est_in;
      out_gain_ff <= out_gain_in;
      out_cov_ff  <= out_cov_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign estimate_out   = out_est_ff;
   assign gain_out       = out_gain_ff;
   assign covariance_out = out_cov_ff;

endmodule

// ===== src/scalar_kalman_filter_top.sv =====
// Scalar Kalman filter, top level. An accepted update word passes through predict,
// denominator, the 16-step gain divider, two passes through the shared multiplier and
// the output load, then rsp_tvalid rises. With P + R of 1 LSB or less the divider and
// the multiplier are skipped; a reset word goes straight to the output load. One word in
// flight at a time: the next word is taken only once the last result is loaded, which rsp_tready can hold back.
// Synchronous active-high reset clears estimate, covariance, gain and the initialized flag.
module scalar_kalman_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [skf_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,  // measurement, reset_estimate,
                                                           // reset_covariance
   input  logic                                req_tuser,  // req_type
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [skf_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,  // estimate_out, gain_out,
                                                           // covariance_out, zero pad
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [skf_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [skf_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [skf_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int Dw = skf_pkg::DATA_WIDTH;

   skf_pkg::csr_regs_type          regs;
   skf_pkg::div_req_type           div_req;
   logic [skf_pkg::GAIN_BITS-1:0]  div_quotient;
   logic                           div_done;
   logic [skf_pkg::MAG_WIDTH-1:0]  mul_a;
   logic [skf_pkg::FACT_WIDTH-1:0] mul_b;
   logic [skf_pkg::PROD_WIDTH-1:0] product;
   logic [Dw-1:0]                  estimate_out;
   logic [skf_pkg::GAIN_BITS-1:0]  gain_out;
   logic [skf_pkg::COV_WIDTH-1:0]  covariance_out;

   skf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   skf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .quotient (div_quotient),
      .done     (div_done)
   );

   skf_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   skf_core u_core (
      .clock            (clock),
      .reset            (reset),
      .regs             (regs),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_kind         (req_tuser),
      .measurement      (req_tdata[Dw-1:0]),
      .reset_estimate   (req_tdata[2*Dw-1:Dw]),
      .reset_covariance (req_tdata[3*Dw-1:2*Dw]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .estimate_out     (estimate_out),
      .gain_out         (gain_out),
      .covariance_out   (covariance_out),
      .div_req          (div_req),
      .div_quotient     (div_quotient),
      .div_done         (div_done),
      .mul_a            (mul_a),
      .mul_b            (mul_b),
      .product          (product)
   );

   assign rsp_tdata = skf_pkg::RSP_TDATA_WIDTH'({covariance_out, gain_out, estimate_out});

   // The core takes one word at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a word is still in work");

   // A new result is only loaded from the busy sequencer
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a word in work");

endmodule

// ===== tb/skf_checker.sv =====
// Scoreboard for the scalar Kalman filter: watches the request, result and register ports,
// predicts every result word from its own copy of the filter state and compares field by field.
// Depends on skf_pkg for widths, register indexes and request kinds.
module skf_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [skf_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,  // measurement, reset_estimate,
                                                           // reset_covariance
   input  logic                                req_tuser,  // req_type
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [skf_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,  // estimate_out, gain_out,
                                                           // covariance_out, zero pad
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [skf_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [skf_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   input  logic                                csr_pready,
   output int                                  mismatch_count,
   output int                                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = skf_pkg::DATA_WIDTH;
   localparam int CW = skf_pkg::COV_WIDTH;
   localparam int GW = skf_pkg::GAIN_BITS;
   localparam longint unsigned COV_CEIL   = (64'd1 << CW) - 1;
   localparam longint unsigned GAIN_UNITY = 64'd1 << GW;
   localparam longint unsigned GAIN_CEIL  = GAIN_UNITY - 1;
   localparam longint          EST_HIGH   = longint'(COV_CEIL);
   localparam longint          EST_LOW    = -EST_HIGH - 1;

   typedef struct packed {
      logic [DW-1:0] estimate;
      logic [GW-1:0] gain;
      logic [CW-1:0] covariance;
   } kalman_result_type;

   // Filter state and noise settings as the block should hold them
   logic signed [DW-1:0] est_q;
   logic [CW-1:0]        cov_q;
   logic [GW-1:0]        gain_q;
   bit                   primed;
   logic [CW-1:0]        q_noise, r_noise, p_start;

   kalman_result_type expected_results[$];

   // One filter step: reset word loads state, update word predicts and corrects
   function automatic kalman_result_type kalman_advance(logic kind, logic [DW-1:0] z_bits,
                                                        logic [DW-1:0] est_bits,
                                                        logic [DW-1:0] cov_bits);
      longint            zs, resid, sum;
      longint unsigned   p, den, g, mag, corr, scaled;
      kalman_result_type r;
      if (kind == skf_pkg::REQ_RESET) begin
         est_q  = est_bits;
         cov_q  = cov_bits[DW-1] ? '0 : cov_bits[CW-1:0];
         gain_q = '0;
         primed = 1'b1;
      end else begin
         zs = longint'($signed(z_bits));
         // first update seeds the estimate from the sample
         if (!primed) begin
            est_q  = z_bits;
            cov_q  = p_start;
            primed = 1'b1;
         end
         p = cov_q;
         p += q_noise;
         if (p > COV_CEIL) p = COV_CEIL;
         cov_q = p[CW-1:0];
         den = p + r_noise;
         if (den <= 1) begin
            // denominator too small: no gain, estimate held
            gain_q = '0;
         end else begin
            g = (p << GW) / den;
            if (g > GAIN_CEIL) g = GAIN_CEIL;
            gain_q = g[GW-1:0];
            resid  = zs - longint'(est_q);
            mag    = (resid < 0) ? longint'(-resid) : longint'(resid);
            // round half away from zero on the magnitude
            corr   = (mag * g + (GAIN_UNITY >> 1)) >> GW;
            sum    = (resid < 0) ? longint'(est_q) - longint'(corr)
                                 : longint'(est_q) + longint'(corr);
            if (sum > EST_HIGH) sum = EST_HIGH;
            if (sum < EST_LOW) sum = EST_LOW;
            est_q  = sum[DW-1:0];
            scaled = (p * (GAIN_UNITY - g)) >> GW;
            cov_q  = scaled[CW-1:0];
         end
      end
      r.estimate   = est_q;
      r.gain       = gain_q;
      r.covariance = cov_q;
      return r;
   endfunction

   always @(posedge clock) begin
      kalman_result_type want, got;
      if (reset) begin
         est_q   = '0;
         cov_q   = '0;
         gain_q  = '0;
         primed  = 1'b0;
         q_noise = skf_pkg::Q_VARIANCE_RESET;
         r_noise = skf_pkg::R_VARIANCE_RESET;
         p_start = skf_pkg::START_COVARIANCE_RESET;
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[skf_pkg::CSR_ADDR_WIDTH-1:2])
               skf_pkg::REG_Q_VARIANCE:        q_noise = csr_pwdata[CW-1:0];
               skf_pkg::REG_R_VARIANCE:        r_noise = csr_pwdata[CW-1:0];
               skf_pkg::REG_START_COVARIANCE:  p_start = csr_pwdata[CW-1:0];
               default: ;
            endcase
         end
         // result word against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.estimate   = rsp_tdata[DW-1:0];
            got.gain       = rsp_tdata[DW+GW-1:DW];
            got.covariance = rsp_tdata[DW+GW+CW-1:DW+GW];
            if (expected_results.size() == 0) begin
               $error("unexpected result word: estimate_out %0d gain_out %0d covariance_out %0d",
                      $signed(got.estimate), got.gain, got.covariance);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.estimate !== want.estimate) begin
                  $error("estimate_out: expected %0d, got %0d",
                         $signed(want.estimate), $signed(got.estimate));
                  mismatch_count++;
               end
               if (got.gain !== want.gain) begin
                  $error("gain_out: expected %0d, got %0d", want.gain, got.gain);
                  mismatch_count++;
               end
               if (got.covariance !== want.covariance) begin
                  $error("covariance_out: expected %0d, got %0d",
                         want.covariance, got.covariance);
                  mismatch_count++;
               end
            end
         end
         // request word: predict its result
         if (req_tvalid && req_tready)
            expected_results.push_back(kalman_advance(req_tuser, req_tdata[DW-1:0],
                                                      req_tdata[2*DW-1:DW],
                                                      req_tdata[3*DW-1:2*DW]));
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== tb/tb_scalar_kalman_filter_top.sv =====
// Testbench top for scalar_kalman_filter_top: clock, reset, register setup and request
// stimulus with random idling on both streams; skf_checker does all the comparing.
// Depends on skf_pkg, skf_checker and the block under src.
module tb_scalar_kalman_filter_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_tvalid, req_tready;
   logic [skf_pkg::REQ_TDATA_WIDTH-1:0] req_tdata;  // measurement, reset_estimate,
                                                    // reset_covariance
   logic                                req_tuser;  // req_type
   logic                                rsp_tvalid, rsp_tready;
   logic [skf_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;  // estimate_out, gain_out,
                                                    // covariance_out, zero pad
   logic                                csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [skf_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr;
   logic [skf_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata, csr_prdata;

   int mismatch_count, pending_count;
   int tx_calm = 0, rx_calm = 0;
   int track_level = 0;

   localparam logic [30:0] NOISE_MAX = '1;

   always #5 clock = ~clock;

   scalar_kalman_filter_top dut (.*);

   skf_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatch_count, .pending_count
   );

   // Idle cycles before the next word, with occasional stretches of none
   function automatic int draw_pause(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
      return $urandom_range(0, 4);
   endfunction

   function automatic logic [30:0] draw_noise();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 31'd1;
         2: return NOISE_MAX;
         3: return 31'($urandom_range(0, 4000));
         4: return 31'($urandom_range(0, 1 << 20));
         default: return 31'($urandom());
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(logic kind, logic [31:0] meas, logic [31:0] rest,
                            logic [31:0] rcov);
      int pause;
      pause = draw_pause(tx_calm);
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {rcov, rest, meas};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Wait until every predicted result word has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Back-to-back register writes, setup then access for each
   task automatic write_noise(logic [30:0] q, logic [30:0] r, logic [30:0] p0);
      logic [30:0] vals[3];
      logic [1:0]  idx[3];
      vals = '{q, r, p0};
      idx  = '{skf_pkg::REG_Q_VARIANCE, skf_pkg::REG_R_VARIANCE,
               skf_pkg::REG_START_COVARIANCE};
      for (int i = 0; i < 3; i++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {idx[i], 2'b00};
         csr_pwdata  <= {1'($urandom()), vals[i]};
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         @(negedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly a slowly drifting signal with noise, some resets, wild samples and extremes
   task automatic send_random_word();
      int          pick;
      logic [31:0] meas, rest, rcov;
      pick = $urandom_range(0, 99);
      meas = $urandom();
      rest = $urandom();
      rcov = $urandom();
      if (pick < 12) begin
         if ($urandom_range(0, 1)) rest = track_level;
         case ($urandom_range(0, 3))
            0: rcov = $urandom_range(0, 1 << 18);
            1: rcov = '0;
            default: ;
         endcase
         send_word(skf_pkg::REQ_RESET, meas, rest, rcov);
      end else begin
         if (pick < 80) begin
            track_level += int'($urandom_range(0, 8192)) - 4096;
            meas = track_level + int'($urandom_range(0, 2048)) - 1024;
         end else if (pick >= 92) begin
            case ($urandom_range(0, 3))
               0: meas = 32'h7fff_ffff;
               1: meas = 32'h8000_0000;
               2: meas = '0;
               default: meas = '1;
            endcase
         end
         send_word(skf_pkg::REQ_UPDATE, meas, rest, rcov);
      end
   endtask

   // Result side: either ready early after a pause, or stall once a word shows up
   initial begin
      int pause;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         pause = draw_pause(rx_calm);
         if ($urandom_range(0, 1)) begin
            if (pause > 0) begin
               rsp_tready <= 1'b0;
               repeat (pause) @(negedge clock);
            end
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            @(negedge clock);
            repeat (pause) @(negedge clock);
            rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Run time limit
   initial begin
      #5_000_000;
      $display("scalar_kalman_filter_top test failed");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = skf_pkg::REQ_UPDATE;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default noise: first update seeds state, field extremes, ignored fields
      send_word(skf_pkg::REQ_UPDATE, 32'h7fff_ffff, '0, '0);
      send_word(skf_pkg::REQ_UPDATE, 32'h8000_0000, '0, '0);
      send_word(skf_pkg::REQ_UPDATE, '0, '1, '1);
      send_word(skf_pkg::REQ_UPDATE, 32'h0001_0000, 32'h1234_5678, 32'h8765_4321);
      send_word(skf_pkg::REQ_RESET, '1, 32'h7fff_ffff, 32'h8000_0000);
      send_word(skf_pkg::REQ_UPDATE, 32'h8000_0000, '0, '0);
      send_word(skf_pkg::REQ_RESET, '0, 32'h8000_0000, 32'h7fff_ffff);
      send_word(skf_pkg::REQ_UPDATE, 32'h7fff_ffff, '0, '0);
      send_word(skf_pkg::REQ_RESET, 32'h5555_aaaa, '0, '1);

      // no noise at all: zero denominator, one-LSB denominator, saturated gain
      settle();
      write_noise('0, '0, '0);
      send_word(skf_pkg::REQ_UPDATE, 32'h0000_1234, '0, '0);
      send_word(skf_pkg::REQ_RESET, '0, 32'd5, 32'd1);
      send_word(skf_pkg::REQ_UPDATE, 32'd100, '0, '0);
      send_word(skf_pkg::REQ_RESET, '0, 32'd5, 32'd2);
      send_word(skf_pkg::REQ_UPDATE, 32'h0002_0000, '0, '0);
      send_word(skf_pkg::REQ_RESET, '0, 32'h7fff_ffff, 32'h7fff_ffff);
      send_word(skf_pkg::REQ_UPDATE, 32'h8000_0000, '0, '0);

      // one-LSB measurement noise with empty covariance
      settle();
      write_noise('0, 31'd1, '0);
      send_word(skf_pkg::REQ_RESET, '0, 32'hffff_0000, '0);
      send_word(skf_pkg::REQ_UPDATE, 32'h0003_0000, '0, '0);

      // largest noise: covariance saturates on predict
      settle();
      write_noise(NOISE_MAX, NOISE_MAX, NOISE_MAX);
      send_word(skf_pkg::REQ_RESET, '0, '0, 32'h7fff_ffff);
      send_word(skf_pkg::REQ_UPDATE, 32'h7fff_ffff, '0, '0);
      send_word(skf_pkg::REQ_UPDATE, 32'h8000_0000, '0, '0);

      // random phases, each under its own noise setting
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         if (ph == 0)
            write_noise(skf_pkg::Q_VARIANCE_RESET, skf_pkg::R_VARIANCE_RESET,
                        skf_pkg::START_COVARIANCE_RESET);
         else
            write_noise(draw_noise(), draw_noise(), draw_noise());
         repeat (175) send_random_word();
      end

      settle();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("scalar_kalman_filter_top test passed");
      else
         $display("scalar_kalman_filter_top test failed");
      $finish;
   end

endmodule
